/* rtl/palt_pkg.sv */
// shared types and constants for the pressure altitude pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package palt_pkg;

    localparam int P_W       = 17;
    localparam int T_W       = 11;
    localparam int G_W       = 16;
    localparam int ALT_W     = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int TK_W      = 20;
    localparam int LOG_W     = 29;
    localparam int E_W       = 28;
    localparam int D_W       = 35;
    localparam int IN_TDATA_W = 48;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PRESSURE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_ALT   = 1'b1;

    localparam logic [P_W-1:0]   REF_PA_RESET    = 17'd101325;
    localparam logic [ALT_W-1:0] SWITCH_M_RESET  = 16'd9000;

    // round(2^24 / 5.257)
    localparam logic signed [22:0] INV_EXP_Q24 = 23'sd3191405;

    // sideband that travels beside the datapath
    typedef struct packed {
        logic            valid;
        logic            p_zero;
        logic            ref_zero;
        logic [TK_W-1:0] tk100;
        logic [G_W-1:0]  gps;
    } t_side;

    typedef struct packed {
        logic [ALT_W-1:0] altitude_m;
        logic             from_gps;
    } t_result;

endpackage

`default_nettype wire

/* rtl/palt_log2.sv */
// four-stage fixed-point log2 in q24 with table lookup and interpolation
// depends on palt_pkg; the table is built at elaboration from ADDR_BITS
`default_nettype none

module palt_log2
    import palt_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [P_W-1:0]   i_x,
    output logic [LOG_W-1:0] o_log
);

    localparam int unsigned ENTRIES   = (1 << ADDR_BITS) + 1;
    localparam int unsigned LOW_SHIFT = 30 - ADDR_BITS;
    localparam int unsigned NORM_W    = P_W + 30;
    localparam int unsigned PROD_W    = 25 + LOW_SHIFT;

    function automatic logic [24:0] log_entry(input int k);
        logic [63:0] y;
        logic [24:0] r;
        y = (64'd1 << 30) + (64'(k) << LOW_SHIFT);
        r = '0;
        if (k == int'(ENTRIES) - 1) begin
            r = 25'd1 << 24;
        end else begin
            for (int i = 0; i < 24; i++) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    r[23-i] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    logic [24:0] lut [ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_lut
        localparam logic [24:0] ENTRY = log_entry(k);
        assign lut[k] = ENTRY;
    end

    // stage 1: leading one and normalise
    logic [4:0]           n_s1_pos;
    logic [NORM_W-1:0]    norm;
    logic [29:0]          frac;
    logic [4:0]           r_s1_pos;
    logic [ADDR_BITS-1:0] r_s1_idx;
    logic [LOW_SHIFT-1:0] r_s1_rem;

    always_comb begin
        n_s1_pos = '0;
        for (int i = 0; i < P_W; i++) begin
            if (i_x[i]) begin
                n_s1_pos = 5'(i);
            end
        end
        norm = NORM_W'(i_x) << (5'd30 - n_s1_pos);
        frac = norm[29:0];
    end

    // stage 2: table reads
    logic [ADDR_BITS:0] idx_lo;
    logic [ADDR_BITS:0] idx_hi;
    logic [24:0]        n_s2_lo;
    logic [24:0]        n_s2_diff;
    logic [4:0]         r_s2_pos;
    logic [24:0]        r_s2_lo;
    logic [24:0]        r_s2_diff;
    logic [LOW_SHIFT-1:0] r_s2_rem;

    always_comb begin
        idx_lo    = {1'b0, r_s1_idx};
        idx_hi    = idx_lo + 1'b1;
        n_s2_lo   = lut[idx_lo];
        n_s2_diff = lut[idx_hi] - lut[idx_lo];
    end

    // stage 3: interpolation product
    logic [PROD_W-1:0] prod;
    logic [4:0]        r_s3_pos;
    logic [24:0]       r_s3_lo;
    logic [24:0]       r_s3_interp;

    assign prod = PROD_W'(r_s2_diff) * PROD_W'(r_s2_rem);

    // stage 4: sum
    logic [LOG_W-1:0] n_log;
    logic [LOG_W-1:0] r_log;

    assign n_log = (LOG_W'(r_s3_pos) << 24) + LOG_W'(r_s3_lo) + LOG_W'(r_s3_interp);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1_pos    <= n_s1_pos;
            r_s1_idx    <= frac[29 -: ADDR_BITS];
            r_s1_rem    <= frac[LOW_SHIFT-1:0];
            r_s2_pos    <= r_s1_pos;
            r_s2_lo     <= n_s2_lo;
            r_s2_diff   <= n_s2_diff;
            r_s2_rem    <= r_s1_rem;
            r_s3_pos    <= r_s2_pos;
            r_s3_lo     <= r_s2_lo;
            r_s3_interp <= prod[PROD_W-1:LOW_SHIFT];
            r_log       <= n_log;
        end
    end

    assign o_log = r_log;

endmodule

`default_nettype wire

/* rtl/palt_log_pair.sv */
// log ratio stage: two log2 units, difference and scaling by 1/5.257
// depends on palt_pkg and palt_log2; six register stages
`default_nettype none

module palt_log_pair
    import palt_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  logic [P_W-1:0]        i_ref,
    input  logic [P_W-1:0]        i_p,
    input  logic [T_W-1:0]        i_temp,
    input  logic [G_W-1:0]        i_gps,
    output logic signed [E_W-1:0] o_e,
    output t_side                 o_side
);

    localparam int LOG_LAT = 4;
    localparam int L_W     = LOG_W + 1;
    localparam int SCL_W   = L_W + 23;

    logic [LOG_W-1:0] log_ref;
    logic [LOG_W-1:0] log_p;

    palt_log2 #(.ADDR_BITS(ADDR_BITS)) u_log_ref (
        .i_clk (i_clk),
        .i_ce  (i_ce),
        .i_x   (i_ref),
        .o_log (log_ref)
    );

    palt_log2 #(.ADDR_BITS(ADDR_BITS)) u_log_p (
        .i_clk (i_clk),
        .i_ce  (i_ce),
        .i_x   (i_p),
        .o_log (log_p)
    );

    // absolute temperature in 0.05 k, times 100
    logic [13:0] tk;
    t_side       n_side;

    always_comb begin
        tk              = {{2{i_temp[T_W-1]}}, i_temp, 1'b0} + 14'd5463;
        n_side.valid    = i_valid;
        n_side.p_zero   = (i_p == '0);
        n_side.ref_zero = (i_ref == '0);
        n_side.tk100    = TK_W'(tk[12:0]) * TK_W'(100);
        n_side.gps      = i_gps;
    end

    t_side                 r_side [LOG_LAT];
    t_side                 r_s5_side;
    t_side                 r_s6_side;
    logic signed [L_W-1:0] n_l;
    logic signed [L_W-1:0] r_s5_l;
    logic signed [SCL_W-1:0] scaled;
    logic signed [E_W-1:0] r_s6_e;

    assign n_l    = $signed({1'b0, log_ref}) - $signed({1'b0, log_p});
    assign scaled = r_s5_l * INV_EXP_Q24;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LOG_LAT; s++) begin
                r_side[s] <= '0;
            end
            r_s5_side <= '0;
            r_s6_side <= '0;
        end else if (i_ce) begin
            r_side[0] <= n_side;
            for (int s = 1; s < LOG_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_s5_side <= r_side[LOG_LAT-1];
            r_s6_side <= r_s5_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s5_l <= n_l;
            r_s6_e <= scaled[E_W+23:24];
        end
    end

    assign o_e    = r_s6_e;
    assign o_side = r_s6_side;

endmodule

`default_nettype wire

/* rtl/palt_exp2.sv */
// exp2 of the scaled log ratio: 24 chained root multiplies, then shift
// depends on palt_pkg; root constants are built at elaboration
`default_nettype none

module palt_exp2
    import palt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic signed [E_W-1:0] i_e,
    input  t_side                 i_side,
    output logic signed [D_W-1:0] o_d,
    output t_side                 o_side
);

    localparam int ROOT_STAGES = 24;
    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
    localparam logic signed [D_W-1:0] D_ONE = 35'sd1 << 30;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != '0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-j) in q30 by repeated square root from 2.0
    function automatic logic [30:0] root_q30(input int j);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 1; i <= ROOT_STAGES; i++) begin
            if (i <= j) begin
                r = isqrt64(r << 30);
            end
        end
        return r[30:0];
    endfunction

    logic [30:0]    n_y  [ROOT_STAGES];
    logic [30:0]    r_y  [ROOT_STAGES];
    logic [23:0]    r_f  [ROOT_STAGES];
    logic [3:0]     r_ip [ROOT_STAGES];
    t_side          r_side [ROOT_STAGES];

    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
        localparam logic [30:0] ROOT = root_q30(g + 1);
        logic [30:0] y_prev;
        logic        f_bit;
        logic [61:0] prod;
        if (g == 0) begin : g_first
            assign y_prev = ONE_Q30;
            assign f_bit  = i_e[23];
        end else begin : g_next
            assign y_prev = r_y[g-1];
            assign f_bit  = r_f[g-1][23-g];
        end
        assign prod   = 62'(y_prev) * 62'(ROOT);
        assign n_y[g] = f_bit ? prod[60:30] : y_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROOT_STAGES; s++) begin
                r_side[s] <= '0;
            end
        end else if (i_ce) begin
            r_side[0] <= i_side;
            for (int s = 1; s < ROOT_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_y[0]  <= n_y[0];
            r_f[0]  <= i_e[23:0];
            r_ip[0] <= i_e[E_W-1:24];
            for (int s = 1; s < ROOT_STAGES; s++) begin
                r_y[s]  <= n_y[s];
                r_f[s]  <= r_f[s-1];
                r_ip[s] <= r_ip[s-1];
            end
        end
    end

    // integer part of the exponent, then subtract one
    logic [D_W-1:0]        y_ext;
    logic [D_W-1:0]        shifted;
    logic [3:0]            amt;
    logic signed [D_W-1:0] n_d;
    logic signed [D_W-1:0] r_d;
    t_side                 r_out_side;

    always_comb begin
        y_ext = D_W'(r_y[ROOT_STAGES-1]);
        amt   = ~r_ip[ROOT_STAGES-1] + 4'd1;
        if (r_ip[ROOT_STAGES-1][3]) begin
            shifted = y_ext >> amt;
        end else begin
            shifted = y_ext << r_ip[ROOT_STAGES-1];
        end
        if (r_side[ROOT_STAGES-1].ref_zero) begin
            n_d = -D_ONE;
        end else begin
            n_d = $signed(shifted) - D_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_side <= '0;
        end else if (i_ce) begin
            r_out_side <= r_side[ROOT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_d    = r_d;
    assign o_side = r_out_side;

endmodule

`default_nettype wire

/* rtl/palt_height.sv */
// height from ratio term and temperature, division by 13, source select
// depends on palt_pkg; three register stages
`default_nettype none

module palt_height
    import palt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic signed [D_W-1:0] i_d,
    input  t_side                 i_side,
    input  logic [ALT_W-1:0]      i_switch,
    output logic                  o_valid,
    output t_result               o_result
);

    localparam int NUM_W  = D_W + TK_W + 1;
    localparam int N_W    = 25;
    localparam int M_W    = 27;
    localparam int QP_W   = N_W + M_W;
    localparam int H_W    = 22;
    // ceil(2^30 / 13): exact quotient for values below 2^25
    localparam logic [M_W-1:0] DIV13_MUL = 27'd82595525;

    logic signed [NUM_W-1:0] n_num;
    logic signed [NUM_W-1:0] r_s1_num;
    t_side                   r_s1_side;
    logic [QP_W-1:0]         n_qprod;
    logic [QP_W-1:0]         r_s2_qprod;
    logic                    r_s2_neg;
    t_side                   r_s2_side;
    logic [H_W-1:0]          h;
    logic                    use_gps;
    t_result                 n_res;
    t_result                 r_s3_res;
    logic                    r_s3_valid;

    assign n_num   = i_d * $signed({1'b0, i_side.tk100});
    // floor by 2^30 is the arithmetic shift; sign handled apart
    assign n_qprod = QP_W'(r_s1_num[30 +: N_W]) * QP_W'(DIV13_MUL);

    always_comb begin
        h       = r_s2_qprod[QP_W-1 -: H_W];
        use_gps = r_s2_side.p_zero || (!r_s2_neg && (h >= H_W'(i_switch)));
        n_res.from_gps = use_gps;
        if (use_gps) begin
            n_res.altitude_m = r_s2_side.gps;
        end else if (r_s2_neg) begin
            n_res.altitude_m = '0;
        end else if (|h[H_W-1:ALT_W]) begin
            n_res.altitude_m = '1;
        end else begin
            n_res.altitude_m = h[ALT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side  <= '0;
            r_s2_side  <= '0;
            r_s3_valid <= 1'b0;
        end else if (i_ce) begin
            r_s1_side  <= i_side;
            r_s2_side  <= r_s1_side;
            r_s3_valid <= r_s2_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1_num   <= n_num;
            r_s2_qprod <= n_qprod;
            r_s2_neg   <= r_s1_num[NUM_W-1];
            r_s3_res   <= n_res;
        end
    end

    assign o_valid  = r_s3_valid;
    assign o_result = r_s3_res;

`ifndef SYNTH
    a_neg_height_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ce && r_s2_side.valid && !r_s2_side.p_zero && r_s2_neg)
        |=> (r_s3_valid && !r_s3_res.from_gps && r_s3_res.altitude_m == '0))
        else $error("negative height did not give a barometric zero");
`endif

endmodule

`default_nettype wire

/* rtl/pressure_altitude_with_gps_fallback.sv */
// pressure altitude with gps fallback, top level
// input stream: one item holds pressure, temperature and gps altitude;
// output stream: one item per input, altitude in metres plus a gps flag.
// config port: write enable, index and data; index 0 is the reference
// pressure, index 1 the switch altitude. write only while no item is in
// flight. both reset to 101325 pa and 9000 m.
// throughput: one item per clock while the skid stage is empty; from
// accept to m_axis_tvalid an item passes six log stages, the chain of 24
// root multiplies in the exp2 unit plus its shift, three height stages
// and the output register.
// reset (synchronous, active low) empties the pipeline and the output.
// when the receiver stalls, the item in flight behind the output register
// goes into a one-entry skid stage; s_axis_tready falls only while the
// skid stage is full, and the whole pipeline then holds.
// depends on palt_pkg, palt_log_pair, palt_exp2 and palt_height
`default_nettype none

module pressure_altitude_with_gps_fallback
    import palt_pkg::*;
#(
    parameter int unsigned LOG_TABLE_ADDR_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pressure_pa [16:0], temperature_decic [27:17], gps_altitude_m [43:28], zero pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // altitude_m [15:0]
    output logic [ALT_W-1:0]      m_axis_tdata,
    // from_gps [0]
    output logic                  m_axis_tuser
);

    logic [P_W-1:0]   r_ref_pa;
    logic [ALT_W-1:0] r_switch_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_pa   <= REF_PA_RESET;
            r_switch_m <= SWITCH_M_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REF_PRESSURE: begin
                    r_ref_pa <= i_cfg_wdata[P_W-1:0];
                end
                CFG_SWITCH_ALT: begin
                    r_switch_m <= i_cfg_wdata[ALT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic                  ce;
    logic signed [E_W-1:0] e_val;
    t_side                 e_side;
    logic signed [D_W-1:0] d_val;
    t_side                 d_side;
    logic                  pipe_valid;
    t_result               pipe_res;

    palt_log_pair #(.ADDR_BITS(LOG_TABLE_ADDR_BITS)) u_log_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_axis_tvalid),
        .i_ref   (r_ref_pa),
        .i_p     (s_axis_tdata[16:0]),
        .i_temp  (s_axis_tdata[27:17]),
        .i_gps   (s_axis_tdata[43:28]),
        .o_e     (e_val),
        .o_side  (e_side)
    );

    palt_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_e     (e_val),
        .i_side  (e_side),
        .o_d     (d_val),
        .o_side  (d_side)
    );

    palt_height u_height (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_d      (d_val),
        .i_side   (d_side),
        .i_switch (r_switch_m),
        .o_valid  (pipe_valid),
        .o_result (pipe_res)
    );

    // output register with one-entry skid stage
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    n_out_valid;
    t_result n_out;
    logic    n_skid_valid;
    t_result n_skid;
    logic    take;

    assign ce            = !r_skid_valid;
    assign s_axis_tready = ce;
    assign take          = ce && pipe_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = take;
                n_out       = pipe_res;
            end
        end else if (take) begin
            n_skid_valid = 1'b1;
            n_skid       = pipe_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.altitude_m;
    assign m_axis_tuser  = r_out.from_gps;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready && pipe_valid))
        else $error("skid stage filled without an output stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("output not empty or input not ready after reset");
`endif

endmodule

`default_nettype wire
